// ----- hw/rtl/md2_pkg.sv -----
// md2 digest shared types, codes and the s-box table
`default_nettype none
package md2_pkg;

  localparam int BLOCK_BYTES = 16;
  localparam int STATE_BYTES = 48;
  localparam int ROUNDS      = 18;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic [1:0] KIND_BYTE     = 2'd1;
  localparam logic [1:0] KIND_END      = 2'd2;
  localparam logic [1:0] KIND_BYTE_END = 2'd3;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] kind;
  } op_t;

  typedef struct packed {
    logic valid;
    op_t  op;
  } push_t;

  localparam logic [7:0] PI_TABLE [256] = '{
    8'd41,  8'd46,  8'd67,  8'd201, 8'd162, 8'd216, 8'd124, 8'd1,
    8'd61,  8'd54,  8'd84,  8'd161, 8'd236, 8'd240, 8'd6,   8'd19,
    8'd98,  8'd167, 8'd5,   8'd243, 8'd192, 8'd199, 8'd115, 8'd140,
    8'd152, 8'd147, 8'd43,  8'd217, 8'd188, 8'd76,  8'd130, 8'd202,
    8'd30,  8'd155, 8'd87,  8'd60,  8'd253, 8'd212, 8'd224, 8'd22,
    8'd103, 8'd66,  8'd111, 8'd24,  8'd138, 8'd23,  8'd229, 8'd18,
    8'd190, 8'd78,  8'd196, 8'd214, 8'd218, 8'd158, 8'd222, 8'd73,
    8'd160, 8'd251, 8'd245, 8'd142, 8'd187, 8'd47,  8'd238, 8'd122,
    8'd169, 8'd104, 8'd121, 8'd145, 8'd21,  8'd178, 8'd7,   8'd63,
    8'd148, 8'd194, 8'd16,  8'd137, 8'd11,  8'd34,  8'd95,  8'd33,
    8'd128, 8'd127, 8'd93,  8'd154, 8'd90,  8'd144, 8'd50,  8'd39,
    8'd53,  8'd62,  8'd204, 8'd231, 8'd191, 8'd247, 8'd151, 8'd3,
    8'd255, 8'd25,  8'd48,  8'd179, 8'd72,  8'd165, 8'd181, 8'd209,
    8'd215, 8'd94,  8'd146, 8'd42,  8'd172, 8'd86,  8'd170, 8'd198,
    8'd79,  8'd184, 8'd56,  8'd210, 8'd150, 8'd164, 8'd125, 8'd182,
    8'd118, 8'd252, 8'd107, 8'd226, 8'd156, 8'd116, 8'd4,   8'd241,
    8'd69,  8'd157, 8'd112, 8'd89,  8'd100, 8'd113, 8'd135, 8'd32,
    8'd134, 8'd91,  8'd207, 8'd101, 8'd230, 8'd45,  8'd168, 8'd2,
    8'd27,  8'd96,  8'd37,  8'd173, 8'd174, 8'd176, 8'd185, 8'd246,
    8'd28,  8'd70,  8'd97,  8'd105, 8'd52,  8'd64,  8'd126, 8'd15,
    8'd85,  8'd71,  8'd163, 8'd35,  8'd221, 8'd81,  8'd175, 8'd58,
    8'd195, 8'd92,  8'd249, 8'd206, 8'd186, 8'd197, 8'd234, 8'd38,
    8'd44,  8'd83,  8'd13,  8'd110, 8'd133, 8'd40,  8'd132, 8'd9,
    8'd211, 8'd223, 8'd205, 8'd244, 8'd65,  8'd129, 8'd77,  8'd82,
    8'd106, 8'd220, 8'd55,  8'd200, 8'd108, 8'd193, 8'd171, 8'd250,
    8'd36,  8'd225, 8'd123, 8'd8,   8'd12,  8'd189, 8'd177, 8'd74,
    8'd120, 8'd136, 8'd149, 8'd139, 8'd227, 8'd99,  8'd232, 8'd109,
    8'd233, 8'd203, 8'd213, 8'd254, 8'd59,  8'd0,   8'd29,  8'd57,
    8'd242, 8'd239, 8'd183, 8'd14,  8'd102, 8'd88,  8'd208, 8'd228,
    8'd166, 8'd119, 8'd114, 8'd248, 8'd235, 8'd117, 8'd75,  8'd10,
    8'd49,  8'd68,  8'd80,  8'd180, 8'd143, 8'd237, 8'd31,  8'd26,
    8'd219, 8'd153, 8'd141, 8'd51,  8'd159, 8'd17,  8'd131, 8'd20
  };

endpackage
`default_nettype wire

// ----- hw/rtl/md2_message_digest.sv -----
// md2 message digest top level
// Takes one message byte per request (tuser marks a byte as present, tlast ends the
// message) and returns the 16 digest bytes in order, tlast on the final one. A byte
// that does not complete a 16-byte block is only stored in the core. A byte that
// completes a block is taken, then the checksum fold runs over the block, the mixing
// state is loaded and the 18 rounds of 48 dependent s-box steps run, one step per
// cycle, which set the rate. The end of a message adds a pad step, a fold, two block
// mixes (message block, then checksum block), 16 digest bytes out and a clear step.
// A four-entry request queue takes input while the core works, until it is full,
// and an output register holds a digest byte while the next request is taken.
`default_nettype none
module md2_message_digest (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // data_byte
  input  wire logic       s_tuser,   // byte_present
  input  wire logic       s_tlast,   // end_of_message
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,   // digest_byte
  output logic            m_tlast    // digest_last
);

  md2_pkg::push_t push;
  md2_pkg::op_t   q_op;
  logic           q_full;
  logic           q_valid;
  logic           q_pop;

  md2_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .q_full   (q_full),
    .push     (push)
  );

  md2_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (q_full),
    .q_valid (q_valid),
    .q_op    (q_op),
    .q_pop   (q_pop)
  );

  md2_core u_core (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_op     (q_op),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule
`default_nettype wire

// ----- hw/rtl/md2_front.sv -----
// md2 input side: request classification and queue push
`default_nettype none
module md2_front (
  input  wire logic          s_tvalid,
  output logic               s_tready,
  input  wire logic [7:0]    s_tdata,   // data_byte
  input  wire logic          s_tuser,   // byte_present
  input  wire logic          s_tlast,   // end_of_message
  input  wire logic          q_full,
  output md2_pkg::push_t     push
);

  logic [1:0] kind;

  always_comb begin
    if (s_tuser && s_tlast) begin
      kind = md2_pkg::KIND_BYTE_END;
    end else if (s_tuser) begin
      kind = md2_pkg::KIND_BYTE;
    end else begin
      kind = md2_pkg::KIND_END;
    end
  end

  assign s_tready     = !q_full;
  // requests with neither a byte nor an end carry no work
  assign push.valid   = s_tvalid && !q_full && (s_tuser || s_tlast);
  assign push.op.data = s_tdata;
  assign push.op.kind = kind;

endmodule
`default_nettype wire

// ----- hw/rtl/md2_queue.sv -----
// md2 request queue between front and core
`default_nettype none
module md2_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire md2_pkg::push_t push,
  output logic                full,
  output logic                q_valid,
  output md2_pkg::op_t        q_op,
  input  wire logic           q_pop
);

  md2_pkg::op_t                 mem [md2_pkg::QUEUE_DEPTH];
  logic [md2_pkg::QUEUE_AW-1:0] wr_ptr;
  logic [md2_pkg::QUEUE_AW-1:0] rd_ptr;
  logic [md2_pkg::QUEUE_AW:0]   count;
  logic                         do_pop;

  assign full    = (count == (md2_pkg::QUEUE_AW + 1)'(md2_pkg::QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign q_op    = mem[rd_ptr];
  assign do_pop  = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem[wr_ptr] <= push.op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push.valid && !do_pop) begin
        count <= count + 1'b1;
      end else if (!push.valid && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/md2_core.sv -----
// md2 core: block buffer, checksum fold, state mixing and digest output
`default_nettype none
module md2_core (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         q_valid,
  input  wire md2_pkg::op_t q_op,
  output logic              q_pop,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [7:0]        m_tdata,
  output logic              m_tlast
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PAD  = 3'd1;
  localparam logic [2:0] ST_FOLD = 3'd2;
  localparam logic [2:0] ST_LOAD = 3'd3;
  localparam logic [2:0] ST_MIX  = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;
  localparam logic [2:0] ST_CLR  = 3'd6;

  localparam logic [5:0] LAST_STEP  = 6'(md2_pkg::STATE_BYTES - 1);
  localparam logic [4:0] LAST_ROUND = 5'(md2_pkg::ROUNDS - 1);

  logic [2:0] state;
  logic [7:0] mix  [md2_pkg::STATE_BYTES];
  logic [7:0] csum [md2_pkg::BLOCK_BYTES];
  logic [7:0] blk  [md2_pkg::BLOCK_BYTES];
  logic [7:0] src  [md2_pkg::BLOCK_BYTES];
  logic [7:0] carry;
  logic [3:0] fill;
  logic [3:0] cnt;
  logic [7:0] t;
  logic [5:0] step;
  logic [4:0] round;
  logic       fin;
  logic       end_pend;
  logic       use_sum;
  logic       has_byte;
  logic       has_end;
  logic [7:0] pad_val;
  logic [7:0] fold_val;
  logic [7:0] mix_val;

  assign q_pop    = (state == ST_IDLE) && q_valid;
  assign has_byte = (q_op.kind == md2_pkg::KIND_BYTE) ||
                    (q_op.kind == md2_pkg::KIND_BYTE_END);
  assign has_end  = (q_op.kind == md2_pkg::KIND_END) ||
                    (q_op.kind == md2_pkg::KIND_BYTE_END);
  assign pad_val  = 8'(5'd16 - {1'b0, fill});
  assign fold_val = csum[0] ^ md2_pkg::PI_TABLE[blk[0] ^ carry];
  assign mix_val  = mix[0] ^ md2_pkg::PI_TABLE[t];

  always_comb begin
    for (int i = 0; i < md2_pkg::BLOCK_BYTES; i++) begin
      src[i] = use_sum ? csum[i] : blk[i];
    end
  end

  // message block buffer, no reset
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (q_valid && has_byte) begin
          blk[fill] <= q_op.data;
        end
      end
      ST_PAD: begin
        for (int i = 0; i < md2_pkg::BLOCK_BYTES; i++) begin
          if (4'(i) >= fill) begin
            blk[i] <= pad_val;
          end
        end
      end
      ST_FOLD: begin
        for (int i = 0; i < md2_pkg::BLOCK_BYTES - 1; i++) begin
          blk[i] <= blk[i + 1];
        end
        blk[md2_pkg::BLOCK_BYTES - 1] <= blk[0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      fill     <= '0;
      carry    <= '0;
      cnt      <= '0;
      t        <= '0;
      step     <= '0;
      round    <= '0;
      fin      <= 1'b0;
      end_pend <= 1'b0;
      use_sum  <= 1'b0;
      m_tvalid <= 1'b0;
      m_tdata  <= '0;
      m_tlast  <= 1'b0;
      for (int i = 0; i < md2_pkg::STATE_BYTES; i++) begin
        mix[i] <= '0;
      end
      for (int i = 0; i < md2_pkg::BLOCK_BYTES; i++) begin
        csum[i] <= '0;
      end
    end else begin
      if (m_tready && (state != ST_OUT)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            fin      <= 1'b0;
            end_pend <= has_end;
            use_sum  <= 1'b0;
            cnt      <= '0;
            if (has_byte) begin
              if (fill == 4'd15) begin
                fill  <= '0;
                state <= ST_FOLD;
              end else begin
                fill <= fill + 1'b1;
                if (has_end) begin
                  state <= ST_PAD;
                end
              end
            end else begin
              state <= ST_PAD;
            end
          end
        end
        ST_PAD: begin
          fin      <= 1'b1;
          end_pend <= 1'b0;
          fill     <= '0;
          cnt      <= '0;
          state    <= ST_FOLD;
        end
        ST_FOLD: begin
          for (int i = 0; i < md2_pkg::BLOCK_BYTES - 1; i++) begin
            csum[i] <= csum[i + 1];
          end
          csum[md2_pkg::BLOCK_BYTES - 1] <= fold_val;
          carry <= fold_val;
          cnt   <= cnt + 1'b1;
          if (cnt == 4'd15) begin
            state <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          for (int i = 0; i < md2_pkg::BLOCK_BYTES; i++) begin
            mix[md2_pkg::BLOCK_BYTES + i]     <= src[i];
            mix[2 * md2_pkg::BLOCK_BYTES + i] <= src[i] ^ mix[i];
          end
          t     <= '0;
          step  <= '0;
          round <= '0;
          state <= ST_MIX;
        end
        ST_MIX: begin
          for (int i = 0; i < md2_pkg::STATE_BYTES - 1; i++) begin
            mix[i] <= mix[i + 1];
          end
          mix[md2_pkg::STATE_BYTES - 1] <= mix_val;
          if (step == LAST_STEP) begin
            step <= '0;
            t    <= mix_val + {3'b000, round};
            if (round == LAST_ROUND) begin
              round <= '0;
              cnt   <= '0;
              if (fin && !use_sum) begin
                use_sum <= 1'b1;
                state   <= ST_LOAD;
              end else if (fin) begin
                state <= ST_OUT;
              end else if (end_pend) begin
                // full block ended the message, padding block still to come
                state <= ST_PAD;
              end else begin
                state <= ST_IDLE;
              end
            end else begin
              round <= round + 1'b1;
            end
          end else begin
            step <= step + 1'b1;
            t    <= mix_val;
          end
        end
        ST_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= mix[0];
            m_tlast  <= (cnt == 4'd15);
            for (int i = 0; i < md2_pkg::STATE_BYTES - 1; i++) begin
              mix[i] <= mix[i + 1];
            end
            mix[md2_pkg::STATE_BYTES - 1] <= mix[0];
            cnt <= cnt + 1'b1;
            if (cnt == 4'd15) begin
              state <= ST_CLR;
            end
          end
        end
        ST_CLR: begin
          for (int i = 0; i < md2_pkg::STATE_BYTES; i++) begin
            mix[i] <= '0;
          end
          for (int i = 0; i < md2_pkg::BLOCK_BYTES; i++) begin
            csum[i] <= '0;
          end
          carry    <= '0;
          fill     <= '0;
          fin      <= 1'b0;
          end_pend <= 1'b0;
          use_sum  <= 1'b0;
          state    <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire
